/* src/ray_sphere_intersect_macros.svh */
// Assertion macros for the ray sphere intersect block
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RSI_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, codes and word types shared by the ray sphere intersect modules.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int Q_W    = 32;
  localparam int OC_W   = 33;
  localparam int DIR_W  = 18;
  localparam int RAD_W  = 31;
  localparam int P_W    = 51;
  localparam int SQ_W   = 65;
  localparam int RR_W   = 62;
  localparam int H_W    = 52;
  localparam int HM_W   = 51;
  localparam int HH_W   = 25;
  localparam int HL_W   = 26;
  localparam int C_W    = 67;
  localparam int H2_W   = 102;
  localparam int ED_W   = 105;
  localparam int E_W    = 104;
  localparam int S_W    = 52;
  localparam int REM_W  = 55;
  localparam int T_W    = 55;

  localparam logic [1:0] HIT_MISS    = 2'd0;
  localparam logic [1:0] HIT_TANGENT = 2'd1;
  localparam logic [1:0] HIT_TWO     = 2'd2;

  typedef struct packed {
    logic [1:0]              cnt;
    logic signed [H_W-1:0]   h;
    logic [E_W-1:0]          e;
  } mid_word_t;

  typedef struct packed {
    logic [1:0]              hit_count;
    logic signed [Q_W-1:0]   t_near;
    logic signed [Q_W-1:0]   t_far;
  } res_word_t;

endpackage

/* src/rsi_queue.sv */
// ----------------------------------------------------------------------------
// rsi_queue
// Word queue: storage array with a registered read into a head register.
// ----------------------------------------------------------------------------
module rsi_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  head_r;
  logic          head_valid_r;
  logic          load;

  assign load = (count_r != '0) && (!head_valid_r || pop);

  always_comb begin
    count_nxt = count_r;
    if (push && !load) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && load) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= din;
    end
    if (load) begin
      head_r <= mem[rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r       <= '0;
      rptr_r       <= '0;
      count_r      <= '0;
      head_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (load) begin
        rptr_r       <= rptr_r + PW'(1);
        head_valid_r <= 1'b1;
      end else if (pop) begin
        head_valid_r <= 1'b0;
      end
    end
  end

  assign valid = head_valid_r;
  assign dout  = head_r;

endmodule

/* src/rsi_front.sv */
// ----------------------------------------------------------------------------
// rsi_front
// Forms oc, h, c and the quarter discriminant, and classifies the hit count.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [rsi_pkg::Q_W-1:0]       origin_x,
  input  logic signed [rsi_pkg::Q_W-1:0]       origin_y,
  input  logic signed [rsi_pkg::Q_W-1:0]       origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]     dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]     dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]     dir_z,
  input  logic signed [rsi_pkg::Q_W-1:0]       center_x,
  input  logic signed [rsi_pkg::Q_W-1:0]       center_y,
  input  logic signed [rsi_pkg::Q_W-1:0]       center_z,
  input  logic [rsi_pkg::RAD_W-1:0]            radius,
  output logic                                 out_valid,
  output rsi_pkg::mid_word_t                   out_word
);

  logic [5:0] vld_r;

  // stage 1
  logic signed [rsi_pkg::OC_W-1:0]  ocx_r, ocy_r, ocz_r, ocx_nxt, ocy_nxt, ocz_nxt;
  logic signed [rsi_pkg::DIR_W-1:0] dx_r, dy_r, dz_r;
  logic [rsi_pkg::RAD_W-1:0]        r_r;
  // stage 2
  logic signed [rsi_pkg::P_W-1:0]   px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic signed [2*rsi_pkg::OC_W-1:0] sqx_full, sqy_full, sqz_full;
  logic [rsi_pkg::SQ_W-1:0]         sqx_r, sqy_r, sqz_r;
  logic [rsi_pkg::RR_W-1:0]         rr_r, rr_nxt;
  // stage 3
  logic signed [rsi_pkg::H_W-1:0]   h3_r, h3_nxt;
  logic signed [rsi_pkg::C_W-1:0]   c3_r, c3_nxt;
  // stage 4
  logic signed [rsi_pkg::H_W-1:0]   habs;
  logic [rsi_pkg::HM_W-1:0]         hm;
  logic [2*rsi_pkg::HH_W-1:0]       hh_r, hh_nxt;
  logic [rsi_pkg::HH_W+rsi_pkg::HL_W-1:0] hl_r, hl_nxt;
  logic [2*rsi_pkg::HL_W-1:0]       ll_r, ll_nxt;
  logic signed [rsi_pkg::H_W-1:0]   h4_r;
  logic signed [rsi_pkg::C_W-1:0]   c4_r;
  // stage 5
  logic [rsi_pkg::H2_W-1:0]         h2_r, h2_nxt;
  logic signed [rsi_pkg::H_W-1:0]   h5_r;
  logic signed [rsi_pkg::C_W-1:0]   c5_r;
  // stage 6
  logic signed [rsi_pkg::ED_W-1:0]  ediff;
  rsi_pkg::mid_word_t               word_r, word_nxt;

  always_comb begin
    ocx_nxt = rsi_pkg::OC_W'(origin_x) - rsi_pkg::OC_W'(center_x);
    ocy_nxt = rsi_pkg::OC_W'(origin_y) - rsi_pkg::OC_W'(center_y);
    ocz_nxt = rsi_pkg::OC_W'(origin_z) - rsi_pkg::OC_W'(center_z);

    px_nxt   = rsi_pkg::P_W'(ocx_r) * rsi_pkg::P_W'(dx_r);
    py_nxt   = rsi_pkg::P_W'(ocy_r) * rsi_pkg::P_W'(dy_r);
    pz_nxt   = rsi_pkg::P_W'(ocz_r) * rsi_pkg::P_W'(dz_r);
    sqx_full = (2*rsi_pkg::OC_W)'(ocx_r) * (2*rsi_pkg::OC_W)'(ocx_r);
    sqy_full = (2*rsi_pkg::OC_W)'(ocy_r) * (2*rsi_pkg::OC_W)'(ocy_r);
    sqz_full = (2*rsi_pkg::OC_W)'(ocz_r) * (2*rsi_pkg::OC_W)'(ocz_r);
    rr_nxt   = rsi_pkg::RR_W'(r_r) * rsi_pkg::RR_W'(r_r);

    h3_nxt = rsi_pkg::H_W'(px_r) + rsi_pkg::H_W'(py_r) + rsi_pkg::H_W'(pz_r);
    c3_nxt = $signed({2'b00, sqx_r}) + $signed({2'b00, sqy_r}) + $signed({2'b00, sqz_r})
           - $signed({5'b00000, rr_r});

    habs   = h3_r[rsi_pkg::H_W-1] ? -h3_r : h3_r;
    hm     = habs[rsi_pkg::HM_W-1:0];
    hh_nxt = (2*rsi_pkg::HH_W)'(hm[rsi_pkg::HM_W-1 -: rsi_pkg::HH_W])
           * (2*rsi_pkg::HH_W)'(hm[rsi_pkg::HM_W-1 -: rsi_pkg::HH_W]);
    hl_nxt = (rsi_pkg::HH_W+rsi_pkg::HL_W)'(hm[rsi_pkg::HM_W-1 -: rsi_pkg::HH_W])
           * (rsi_pkg::HH_W+rsi_pkg::HL_W)'(hm[rsi_pkg::HL_W-1:0]);
    ll_nxt = (2*rsi_pkg::HL_W)'(hm[rsi_pkg::HL_W-1:0])
           * (2*rsi_pkg::HL_W)'(hm[rsi_pkg::HL_W-1:0]);

    // cross term counts twice
    h2_nxt = (rsi_pkg::H2_W'(hh_r) << (2*rsi_pkg::HL_W))
           + (rsi_pkg::H2_W'(hl_r) << (rsi_pkg::HL_W + 1))
           + rsi_pkg::H2_W'(ll_r);

    ediff = $signed({3'b000, h2_r}) - rsi_pkg::ED_W'($signed({c5_r, 32'd0}));
    word_nxt.h = h5_r;
    if (ediff[rsi_pkg::ED_W-1]) begin
      word_nxt.cnt = rsi_pkg::HIT_MISS;
      word_nxt.e   = '0;
    end else if (ediff == '0) begin
      word_nxt.cnt = rsi_pkg::HIT_TANGENT;
      word_nxt.e   = '0;
    end else begin
      word_nxt.cnt = rsi_pkg::HIT_TWO;
      word_nxt.e   = ediff[rsi_pkg::E_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    ocx_r <= ocx_nxt;
    ocy_r <= ocy_nxt;
    ocz_r <= ocz_nxt;
    dx_r  <= dir_x;
    dy_r  <= dir_y;
    dz_r  <= dir_z;
    r_r   <= radius;

    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pz_r  <= pz_nxt;
    sqx_r <= sqx_full[rsi_pkg::SQ_W-1:0];
    sqy_r <= sqy_full[rsi_pkg::SQ_W-1:0];
    sqz_r <= sqz_full[rsi_pkg::SQ_W-1:0];
    rr_r  <= rr_nxt;

    h3_r <= h3_nxt;
    c3_r <= c3_nxt;

    hh_r <= hh_nxt;
    hl_r <= hl_nxt;
    ll_r <= ll_nxt;
    h4_r <= h3_r;
    c4_r <= c3_r;

    h2_r <= h2_nxt;
    h5_r <= h4_r;
    c5_r <= c4_r;

    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  assign out_valid = vld_r[5];
  assign out_word  = word_r;

endmodule

/* src/rsi_back.sv */
// ----------------------------------------------------------------------------
// rsi_back
// Pipelined square root, one root bit per stage, then rounding and saturation.
// ----------------------------------------------------------------------------
module rsi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rsi_pkg::mid_word_t   in_word,
  output logic                 out_valid,
  output rsi_pkg::res_word_t   out_word
);

  localparam int NS = rsi_pkg::S_W;
  localparam logic signed [rsi_pkg::T_W-1:0] QMAX = rsi_pkg::T_W'(64'sd2147483647);
  localparam logic signed [rsi_pkg::T_W-1:0] QMIN = rsi_pkg::T_W'(-64'sd2147483648);

  logic [NS:0]                    stg_v_r;
  logic [rsi_pkg::E_W-1:0]        stg_rad_r [NS+1];
  logic [rsi_pkg::REM_W-1:0]      stg_rem_r [NS+1];
  logic [rsi_pkg::S_W-1:0]        stg_q_r   [NS+1];
  logic signed [rsi_pkg::H_W-1:0] stg_h_r   [NS+1];
  logic [1:0]                     stg_cnt_r [NS+1];

  logic signed [rsi_pkg::T_W-1:0] nh, sx, tn, tf;
  rsi_pkg::res_word_t             res_r, res_nxt;
  logic                           out_v_r;

  function automatic logic signed [rsi_pkg::Q_W-1:0] rnd_sat(
      input logic signed [rsi_pkg::T_W-1:0] x);
    logic signed [rsi_pkg::T_W-1:0] y;
    y = (x + rsi_pkg::T_W'(32768)) >>> 16;
    if (y > QMAX) begin
      y = QMAX;
    end else if (y < QMIN) begin
      y = QMIN;
    end
    return y[rsi_pkg::Q_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    stg_rad_r[0] <= in_word.e;
    stg_rem_r[0] <= '0;
    stg_q_r[0]   <= '0;
    stg_h_r[0]   <= in_word.h;
    stg_cnt_r[0] <= in_word.cnt;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [rsi_pkg::REM_W-1:0] rem_sh, trial, rem_n;
    logic                      ge;

    always_comb begin
      rem_sh = {stg_rem_r[k][rsi_pkg::REM_W-3:0], stg_rad_r[k][rsi_pkg::E_W-1 -: 2]};
      trial  = rsi_pkg::REM_W'({stg_q_r[k], 2'b01});
      ge     = rem_sh >= trial;
      rem_n  = ge ? rem_sh - trial : rem_sh;
    end

    always_ff @(posedge clk) begin
      stg_rad_r[k+1] <= stg_rad_r[k] << 2;
      stg_rem_r[k+1] <= rem_n;
      stg_q_r[k+1]   <= {stg_q_r[k][rsi_pkg::S_W-2:0], ge};
      stg_h_r[k+1]   <= stg_h_r[k];
      stg_cnt_r[k+1] <= stg_cnt_r[k];
    end
  end

  always_comb begin
    nh = -rsi_pkg::T_W'(stg_h_r[NS]);
    sx = $signed({3'b000, stg_q_r[NS]});
    tn = nh - sx;
    tf = nh + sx;
    res_nxt.hit_count = stg_cnt_r[NS];
    if (stg_cnt_r[NS] == rsi_pkg::HIT_MISS) begin
      res_nxt.t_near = '0;
      res_nxt.t_far  = '0;
    end else begin
      res_nxt.t_near = rnd_sat(tn);
      res_nxt.t_far  = rnd_sat(tf);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= {stg_v_r[NS-1:0], in_valid};
      out_v_r <= stg_v_r[NS];
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = res_r;

endmodule

/* src/ray_sphere_intersect.sv */
// Path: front pipeline, middle queue, back root pipeline, result queue, in that order.
// Throughput: one word per cycle while in_full is low; in_full rises only once the
// result side has stalled long enough to fill the back pipeline, the result queue
// and the 17 front/middle slots.
// Reset: synchronous active low rst_n empties both queues and all valid bits.
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against sphere hit test in Q16.16: front classifier, queue, root pipeline.
// ----------------------------------------------------------------------------
module ray_sphere_intersect #(
  parameter int MID_DEPTH = 16,
  parameter int OUT_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [rsi_pkg::Q_W-1:0]    in_origin_x,
  input  logic signed [rsi_pkg::Q_W-1:0]    in_origin_y,
  input  logic signed [rsi_pkg::Q_W-1:0]    in_origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_z,
  input  logic signed [rsi_pkg::Q_W-1:0]    in_center_x,
  input  logic signed [rsi_pkg::Q_W-1:0]    in_center_y,
  input  logic signed [rsi_pkg::Q_W-1:0]    in_center_z,
  input  logic [rsi_pkg::RAD_W-1:0]         in_radius,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [1:0]                        out_hit_count,
  output logic signed [rsi_pkg::Q_W-1:0]    out_t_near,
  output logic signed [rsi_pkg::Q_W-1:0]    out_t_far
);

  localparam int MID_CAP = MID_DEPTH + 1;
  localparam int OUT_CAP = OUT_DEPTH + 1;
  localparam int MU_W    = $clog2(MID_CAP + 1);
  localparam int OU_W    = $clog2(OUT_CAP + 1);
  localparam int MW_W    = $bits(rsi_pkg::mid_word_t);
  localparam int RW_W    = $bits(rsi_pkg::res_word_t);

  logic               acc_in, take, pop_out;
  logic               fr_valid, mid_valid, bk_valid, oq_valid;
  rsi_pkg::mid_word_t fr_word, mid_word, mid_word_q;
  rsi_pkg::res_word_t bk_word, oq_word;
  logic [MW_W-1:0]    mid_dout;
  logic [RW_W-1:0]    oq_dout;
  logic [MU_W-1:0]    mid_used_r;
  logic [OU_W-1:0]    out_used_r;

  assign acc_in  = in_push && !in_full;
  assign in_full = (mid_used_r == MU_W'(MID_CAP));
  assign take    = mid_valid && (out_used_r != OU_W'(OUT_CAP));
  assign pop_out = out_pop && oq_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_used_r <= '0;
      out_used_r <= '0;
    end else begin
      mid_used_r <= mid_used_r + MU_W'(acc_in) - MU_W'(take);
      out_used_r <= out_used_r + OU_W'(take) - OU_W'(pop_out);
    end
  end

  rsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc_in),
    .origin_x  (in_origin_x),
    .origin_y  (in_origin_y),
    .origin_z  (in_origin_z),
    .dir_x     (in_dir_x),
    .dir_y     (in_dir_y),
    .dir_z     (in_dir_z),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .center_z  (in_center_z),
    .radius    (in_radius),
    .out_valid (fr_valid),
    .out_word  (fr_word)
  );

  rsi_queue #(.W(MW_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .din   (fr_word),
    .pop   (take),
    .valid (mid_valid),
    .dout  (mid_dout)
  );

  assign mid_word_q = rsi_pkg::mid_word_t'(mid_dout);
  assign mid_word   = mid_word_q;

  rsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (take),
    .in_word   (mid_word),
    .out_valid (bk_valid),
    .out_word  (bk_word)
  );

  rsi_queue #(.W(RW_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_valid),
    .din   (bk_word),
    .pop   (pop_out),
    .valid (oq_valid),
    .dout  (oq_dout)
  );

  assign oq_word       = rsi_pkg::res_word_t'(oq_dout);
  assign out_empty     = !oq_valid;
  assign out_hit_count = oq_word.hit_count;
  assign out_t_near    = oq_word.t_near;
  assign out_t_far     = oq_word.t_far;

endmodule

/* src/rsi_checker.sv */
// ----------------------------------------------------------------------------
// rsi_checker
// Port level checks on result words of the ray sphere intersect block.
// ----------------------------------------------------------------------------
`include "ray_sphere_intersect_macros.svh"

module rsi_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [1:0]                        out_hit_count,
  input logic signed [rsi_pkg::Q_W-1:0]    out_t_near,
  input logic signed [rsi_pkg::Q_W-1:0]    out_t_far
);

  logic shown, miss_w, tan_w, two_w;

  assign shown  = !out_empty;
  assign miss_w = shown && out_hit_count == rsi_pkg::HIT_MISS;
  assign tan_w  = shown && out_hit_count == rsi_pkg::HIT_TANGENT;
  assign two_w  = shown && out_hit_count == rsi_pkg::HIT_TWO;

  `RSI_ASSERT_IMPLY(a_count_range, shown, out_hit_count != 2'd3, "hit count out of range")
  `RSI_ASSERT_IMPLY(a_miss_zero, miss_w, out_t_near == '0 && out_t_far == '0, "t set on miss")
  `RSI_ASSERT_IMPLY(a_tangent_eq, tan_w, out_t_near == out_t_far, "tangent t differ")
  `RSI_ASSERT_IMPLY(a_two_order, two_w, out_t_near <= out_t_far, "t_near above t_far")
  `RSI_ASSERT_NEXT(a_hold, shown && !out_pop, shown && $stable(out_t_near), "word changed")

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
